### design/rip_pkg.sv
`default_nettype none

package rip_pkg;

	localparam int CHAR_BITS  = 8;
	localparam int BASE_BITS  = 6;
	localparam int COUNT_BITS = 16;
	localparam int PORT_BITS  = 64;

	localparam logic [CHAR_BITS-1:0] CHAR_NUL = 8'h00;
	localparam logic [CHAR_BITS-1:0] CHAR_0   = 8'h30;
	localparam logic [CHAR_BITS-1:0] CHAR_9   = 8'h39;
	localparam logic [CHAR_BITS-1:0] CHAR_LX  = 8'h78;
	localparam logic [CHAR_BITS-1:0] CHAR_UX  = 8'h58;
	localparam logic [CHAR_BITS-1:0] CHAR_LA  = 8'h61;
	localparam logic [CHAR_BITS-1:0] CHAR_LZ  = 8'h7A;
	localparam logic [CHAR_BITS-1:0] CHAR_UA  = 8'h41;
	localparam logic [CHAR_BITS-1:0] CHAR_UZ  = 8'h5A;

	localparam logic [BASE_BITS-1:0] BASE_AUTO   = 6'd0;
	localparam logic [BASE_BITS-1:0] BASE_OCT    = 6'd8;
	localparam logic [BASE_BITS-1:0] BASE_DEC    = 6'd10;
	localparam logic [BASE_BITS-1:0] BASE_HEX    = 6'd16;
	localparam logic [BASE_BITS-1:0] LETTER_BASE = 6'd10;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [PORT_BITS-1:0]  value;
		logic [COUNT_BITS-1:0] count;
		logic                  status;
	} rip_result_t;

	typedef struct packed {
		logic        valid;
		rip_result_t result;
	} rip_emit_t;

	typedef struct packed {
		logic valid;
		logic overflow;
	} rip_digit_t;

endpackage

`default_nettype wire

### design/rip_ifs.sv
`default_nettype none

interface rip_char_if;
	logic                          valid;
	logic                          ready;
	logic [rip_pkg::CHAR_BITS-1:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

interface rip_result_if;
	logic                           valid;
	logic                           ready;
	logic [rip_pkg::PORT_BITS-1:0]  parsed_value;
	logic [rip_pkg::COUNT_BITS-1:0] consumed_count;
	logic                           status;

	modport source (output valid, output parsed_value, output consumed_count, output status,
		input ready);
	modport sink (input valid, input parsed_value, input consumed_count, input status,
		output ready);
endinterface

`default_nettype wire

### design/rip_digit.sv
`default_nettype none

module rip_digit #(
	parameter int VALUE_BITS = 64
) (
	input  wire logic [rip_pkg::CHAR_BITS-1:0]  char_code,
	input  wire logic [rip_pkg::BASE_BITS-1:0]  base,
	input  wire logic [VALUE_BITS-1:0]          acc,
	input  wire logic [rip_pkg::COUNT_BITS-1:0] count,
	output rip_pkg::rip_digit_t                 flags,
	output logic [VALUE_BITS-1:0]               acc_next,
	output logic [rip_pkg::COUNT_BITS-1:0]      count_next
);

	localparam int PROD_BITS = VALUE_BITS + rip_pkg::BASE_BITS;
	localparam int SUM_BITS  = PROD_BITS + 1;

	logic                          is_alnum;
	logic [rip_pkg::BASE_BITS-1:0] digit_val;
	logic [PROD_BITS-1:0]          prod;
	logic [SUM_BITS-1:0]           sum;

	always_comb begin
		is_alnum  = 1'b1;
		digit_val = '0;
		if (char_code inside {[rip_pkg::CHAR_0:rip_pkg::CHAR_9]}) begin
			digit_val = rip_pkg::BASE_BITS'(char_code - rip_pkg::CHAR_0);
		end else if (char_code inside {[rip_pkg::CHAR_LA:rip_pkg::CHAR_LZ]}) begin
			digit_val = rip_pkg::BASE_BITS'(char_code - rip_pkg::CHAR_LA) + rip_pkg::LETTER_BASE;
		end else if (char_code inside {[rip_pkg::CHAR_UA:rip_pkg::CHAR_UZ]}) begin
			digit_val = rip_pkg::BASE_BITS'(char_code - rip_pkg::CHAR_UA) + rip_pkg::LETTER_BASE;
		end else begin
			is_alnum = 1'b0;
		end
	end

	assign prod = PROD_BITS'(acc) * PROD_BITS'(base);
	assign sum  = SUM_BITS'(prod) + SUM_BITS'(digit_val);

	assign flags.valid    = is_alnum && (digit_val < base);
	assign flags.overflow = |sum[SUM_BITS-1:VALUE_BITS];
	assign acc_next       = sum[VALUE_BITS-1:0];
	assign count_next     = (count == rip_pkg::COUNT_MAX) ? count : count + 1'b1;

endmodule

`default_nettype wire

### design/rip_parse.sv
`default_nettype none

module rip_parse #(
	parameter int VALUE_BITS = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire logic [rip_pkg::CHAR_BITS-1:0] char_code,
	input  wire logic [rip_pkg::BASE_BITS-1:0] radix,
	output rip_pkg::rip_emit_t                 emit
);

	typedef enum logic [2:0] {
		PH_START      = 3'd0,
		PH_AUTO_ZERO  = 3'd1,
		PH_HEX_ZERO   = 3'd2,
		PH_HEX_ZERO_X = 3'd3,
		PH_DIGITS     = 3'd4
	} phase_t;

	phase_t                         phase_q, phase_n;
	logic [VALUE_BITS-1:0]          acc_q, acc_n, dig_acc;
	logic [rip_pkg::COUNT_BITS-1:0] count_q, count_mid, count_n, dig_count;
	logic [rip_pkg::BASE_BITS-1:0]  base_q, base_mid;
	logic                           stopped_q, stopped_n;
	logic                           ovf_q, ovf_n;
	logic                           fall, is_nul, is_x, is_zero, feed, emit_now;
	rip_pkg::rip_digit_t            dig;

	assign is_nul  = (char_code == rip_pkg::CHAR_NUL);
	assign is_zero = (char_code == rip_pkg::CHAR_0);
	assign is_x    = (char_code == rip_pkg::CHAR_LX) || (char_code == rip_pkg::CHAR_UX);

	always_comb begin
		phase_n   = phase_q;
		base_mid  = base_q;
		count_mid = count_q;
		fall      = 1'b0;
		case (phase_q)
			PH_START: begin
				if (is_nul) begin
					fall = 1'b1;
				end else if (radix == rip_pkg::BASE_AUTO) begin
					if (is_zero) begin
						phase_n = PH_AUTO_ZERO;
					end else begin
						base_mid = rip_pkg::BASE_DEC;
						phase_n  = PH_DIGITS;
						fall     = 1'b1;
					end
				end else if (radix == rip_pkg::BASE_HEX && is_zero) begin
					base_mid = rip_pkg::BASE_HEX;
					phase_n  = PH_HEX_ZERO;
				end else begin
					base_mid = radix;
					phase_n  = PH_DIGITS;
					fall     = 1'b1;
				end
			end
			PH_AUTO_ZERO: begin
				phase_n = PH_DIGITS;
				if (is_x) begin
					base_mid  = rip_pkg::BASE_HEX;
					count_mid = 16'd2;
				end else begin
					base_mid  = rip_pkg::BASE_OCT;
					count_mid = 16'd1;
					fall      = 1'b1;
				end
			end
			PH_HEX_ZERO: begin
				if (is_x) begin
					phase_n = PH_HEX_ZERO_X;
				end else begin
					count_mid = 16'd1;
					phase_n   = PH_DIGITS;
					fall      = 1'b1;
				end
			end
			PH_HEX_ZERO_X: begin
				phase_n   = PH_DIGITS;
				count_mid = is_nul ? 16'd1 : 16'd2;
				fall      = 1'b1;
			end
			default: begin
				fall = 1'b1;
			end
		endcase
	end

	rip_digit #(
		.VALUE_BITS(VALUE_BITS)
	) u_digit (
		.char_code (char_code),
		.base      (base_mid),
		.acc       (acc_q),
		.count     (count_mid),
		.flags     (dig),
		.acc_next  (dig_acc),
		.count_next(dig_count)
	);

	assign emit_now = fall && is_nul;
	assign feed     = fall && !is_nul && !stopped_q && !ovf_q;

	always_comb begin
		acc_n     = acc_q;
		count_n   = count_mid;
		stopped_n = stopped_q;
		ovf_n     = ovf_q;
		if (feed) begin
			if (!dig.valid) begin
				stopped_n = 1'b1;
			end else if (dig.overflow) begin
				ovf_n = 1'b1;
			end else begin
				acc_n   = dig_acc;
				count_n = dig_count;
			end
		end
	end

	always_comb begin
		emit.valid = emit_now;
		if (ovf_q) begin
			emit.result.value  = '0;
			emit.result.count  = '0;
			emit.result.status = 1'b1;
		end else begin
			emit.result.value  = rip_pkg::PORT_BITS'(acc_q);
			emit.result.count  = count_mid;
			emit.result.status = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			acc_q     <= '0;
			count_q   <= '0;
			base_q    <= '0;
			stopped_q <= 1'b0;
			ovf_q     <= 1'b0;
		end else if (step) begin
			if (emit_now) begin
				phase_q   <= PH_START;
				acc_q     <= '0;
				count_q   <= '0;
				base_q    <= '0;
				stopped_q <= 1'b0;
				ovf_q     <= 1'b0;
			end else begin
				phase_q   <= phase_n;
				acc_q     <= acc_n;
				count_q   <= count_n;
				base_q    <= base_mid;
				stopped_q <= stopped_n;
				ovf_q     <= ovf_n;
			end
		end
	end

endmodule

`default_nettype wire

### design/ascii_radix_integer_parser_core.sv
// Path: an accepted terminator is held in the input register, and when the parser takes it
// its result is registered in the output register that drives the result port.
// Throughput: one character per cycle, set by the single multiply-add that feeds the
// accumulator back to itself; a terminator waits while an untaken result is still held.
// Reset: arst_n clears the radix to automatic detection, empties the input and output
// registers, and returns the parser to the start of a string.
`default_nettype none

module ascii_radix_integer_parser_core #(
	parameter int VALUE_BITS = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [rip_pkg::BASE_BITS-1:0] cfg_wr_data,
	rip_char_if.sink                           char_in,
	rip_result_if.source                       result_out
);

	logic [rip_pkg::BASE_BITS-1:0] radix_q;
	logic [rip_pkg::CHAR_BITS-1:0] char_s1;
	logic                          valid_s1;
	logic                          out_valid_q;
	rip_pkg::rip_result_t          out_q;
	rip_pkg::rip_emit_t            emit;
	logic                          out_free;
	logic                          s1_adv;
	logic                          in_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= rip_pkg::BASE_AUTO;
		end else if (cfg_wr_en) begin
			radix_q <= cfg_wr_data;
		end
	end

	assign out_free      = !out_valid_q || result_out.ready;
	assign s1_adv        = valid_s1 && (!emit.valid || out_free);
	assign char_in.ready = !valid_s1 || s1_adv;
	assign in_take       = char_in.valid && char_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			char_s1 <= char_in.char_code;
		end
	end

	rip_parse #(
		.VALUE_BITS(VALUE_BITS)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (s1_adv),
		.char_code(char_s1),
		.radix    (radix_q),
		.emit     (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit.valid) begin
			out_q <= emit.result;
		end
	end

	assign result_out.valid          = out_valid_q;
	assign result_out.parsed_value   = out_q.value;
	assign result_out.consumed_count = out_q.count;
	assign result_out.status         = out_q.status;

	// A held character must stay in place until the parser can take it.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |=> valid_s1 && $stable(char_s1))
		else $error("input stage lost or changed a waiting character");

	a_emit_on_nul: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && emit.valid |-> char_s1 == rip_pkg::CHAR_NUL)
		else $error("result produced for a character other than the terminator");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && emit.valid |-> !out_valid_q || result_out.ready)
		else $error("result register overwritten before its transaction");

	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && result_out.status |->
			result_out.parsed_value == '0 && result_out.consumed_count == '0)
		else $error("overflow result carries a nonzero value or count");

endmodule

`default_nettype wire

### test/tb_ascii_radix_integer_parser_core.sv
`default_nettype none

module tb_ascii_radix_integer_parser_core;

	typedef enum logic [2:0] {
		AT_START,
		SEEN_ZERO,
		HEX_ZERO,
		HEX_ZERO_X,
		IN_DIGITS
	} parse_phase_t;

	class parse_scoreboard_t;
		rip_pkg::rip_result_t                expected_q[$];
		int                                  errors;
		logic [rip_pkg::BASE_BITS-1:0]       radix;
		parse_phase_t                        phase;
		logic [rip_pkg::PORT_BITS-1:0]       acc;
		logic [rip_pkg::COUNT_BITS-1:0]      count;
		logic [rip_pkg::BASE_BITS-1:0]       base;
		bit                                  stopped;
		bit                                  overflowed;

		function new();
			errors = 0;
			radix = rip_pkg::BASE_AUTO;
			clear_string();
		endfunction

		function void clear_string();
			phase = AT_START;
			acc = '0;
			count = '0;
			base = '0;
			stopped = 1'b0;
			overflowed = 1'b0;
		endfunction

		function void set_radix(input logic [rip_pkg::BASE_BITS-1:0] r);
			radix = r;
		endfunction

		function void finish_string();
			rip_pkg::rip_result_t r;
			if (overflowed) begin
				r.value = '0;
				r.count = '0;
				r.status = 1'b1;
			end else begin
				r.value = acc;
				r.count = count;
				r.status = 1'b0;
			end
			expected_q.push_back(r);
			clear_string();
		endfunction

		// Called for every accepted character transaction.
		function void note_char(input logic [rip_pkg::CHAR_BITS-1:0] c);
			logic [rip_pkg::BASE_BITS-1:0] v;
			logic [rip_pkg::PORT_BITS-1:0] lim;
			case (phase)
				AT_START: begin
					if (c == rip_pkg::CHAR_NUL) begin
						finish_string();
						return;
					end
					if (radix == rip_pkg::BASE_AUTO) begin
						if (c == rip_pkg::CHAR_0) begin
							phase = SEEN_ZERO;
							return;
						end
						base = rip_pkg::BASE_DEC;
					end else if (radix == rip_pkg::BASE_HEX && c == rip_pkg::CHAR_0) begin
						base = rip_pkg::BASE_HEX;
						phase = HEX_ZERO;
						return;
					end else begin
						base = radix;
					end
					phase = IN_DIGITS;
				end
				SEEN_ZERO: begin
					if (c == rip_pkg::CHAR_LX || c == rip_pkg::CHAR_UX) begin
						base = rip_pkg::BASE_HEX;
						count = rip_pkg::COUNT_BITS'(2);
						phase = IN_DIGITS;
						return;
					end
					base = rip_pkg::BASE_OCT;
					count = rip_pkg::COUNT_BITS'(1);
					phase = IN_DIGITS;
				end
				HEX_ZERO: begin
					if (c == rip_pkg::CHAR_LX || c == rip_pkg::CHAR_UX) begin
						phase = HEX_ZERO_X;
						return;
					end
					count = rip_pkg::COUNT_BITS'(1);
					phase = IN_DIGITS;
				end
				HEX_ZERO_X: begin
					if (c == rip_pkg::CHAR_NUL) begin
						count = rip_pkg::COUNT_BITS'(1);
						finish_string();
						return;
					end
					count = rip_pkg::COUNT_BITS'(2);
					phase = IN_DIGITS;
				end
				default: begin
				end
			endcase
			if (c == rip_pkg::CHAR_NUL) begin
				finish_string();
				return;
			end
			if (stopped || overflowed)
				return;
			if (c >= rip_pkg::CHAR_0 && c <= rip_pkg::CHAR_9)
				v = rip_pkg::BASE_BITS'(c - rip_pkg::CHAR_0);
			else if (c >= rip_pkg::CHAR_LA && c <= rip_pkg::CHAR_LZ)
				v = rip_pkg::BASE_BITS'(c - rip_pkg::CHAR_LA) + rip_pkg::LETTER_BASE;
			else if (c >= rip_pkg::CHAR_UA && c <= rip_pkg::CHAR_UZ)
				v = rip_pkg::BASE_BITS'(c - rip_pkg::CHAR_UA) + rip_pkg::LETTER_BASE;
			else begin
				stopped = 1'b1;
				return;
			end
			if (v >= base) begin
				stopped = 1'b1;
				return;
			end
			lim = ({rip_pkg::PORT_BITS{1'b1}} - rip_pkg::PORT_BITS'(v))
				/ rip_pkg::PORT_BITS'(base);
			if (acc > lim) begin
				overflowed = 1'b1;
				return;
			end
			acc = acc * rip_pkg::PORT_BITS'(base) + rip_pkg::PORT_BITS'(v);
			if (count != rip_pkg::COUNT_MAX)
				count = count + 1'b1;
		endfunction

		function void check_result(input logic [rip_pkg::PORT_BITS-1:0] value,
			input logic [rip_pkg::COUNT_BITS-1:0] cnt, input logic status);
			rip_pkg::rip_result_t e;
			if (expected_q.size() == 0) begin
				$error("Result transaction with no expected result: value %0d, count %0d, status %0d",
					value, cnt, status);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (value !== e.value) begin
				$error("parsed_value: expected %0d, got %0d", e.value, value);
				errors++;
			end
			if (cnt !== e.count) begin
				$error("consumed_count: expected %0d, got %0d", e.count, cnt);
				errors++;
			end
			if (status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, status);
				errors++;
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_wr_en;
	logic [rip_pkg::BASE_BITS-1:0] cfg_wr_data;

	rip_char_if   char_if();
	rip_result_if result_if();

	parse_scoreboard_t sb;
	int                send_pct;
	int                stall_pct;
	bit                hold_req;
	int                chars_sent;

	ascii_radix_integer_parser_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.char_in     (char_if),
		.result_out  (result_if)
	);

	always #1 clk = ~clk;

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	// Result side: checks accepted results and stalls at random or for a long hold-off.
	initial begin : result_sink
		int hold_left;
		bit hold_seen;
		hold_left = 0;
		hold_seen = 1'b0;
		result_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (result_if.valid && result_if.ready)
				sb.check_result(result_if.parsed_value, result_if.consumed_count,
					result_if.status);
			if (hold_req && !hold_seen) begin
				hold_left = 300;
				hold_seen = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= ($urandom_range(1, 100) > stall_pct);
			end
		end
	end

	task automatic push_char(input logic [rip_pkg::CHAR_BITS-1:0] c);
		while ($urandom_range(1, 100) <= send_pct) begin
			char_if.valid <= 1'b0;
			@(posedge clk);
		end
		char_if.valid <= 1'b1;
		char_if.char_code <= c;
		@(posedge clk);
		while (!char_if.ready)
			@(posedge clk);
		sb.note_char(c);
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i]);
		push_char(rip_pkg::CHAR_NUL);
	endtask

	task automatic wait_drain();
		int n;
		n = 0;
		char_if.valid <= 1'b0;
		while (sb.expected_q.size() > 0 && n < 100000) begin
			@(posedge clk);
			n++;
		end
		repeat (6) @(posedge clk);
	endtask

	task automatic write_radix(input logic [rip_pkg::BASE_BITS-1:0] r);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= r;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_radix(r);
	endtask

	function automatic logic [rip_pkg::CHAR_BITS-1:0] digit_char(input int val);
		if (val < 10)
			return rip_pkg::CHAR_0 + rip_pkg::CHAR_BITS'(val);
		return ($urandom_range(0, 1) ? rip_pkg::CHAR_LA : rip_pkg::CHAR_UA)
			+ rip_pkg::CHAR_BITS'(val - 10);
	endfunction

	task automatic send_random_string(input logic [rip_pkg::BASE_BITS-1:0] r);
		logic [rip_pkg::CHAR_BITS-1:0] text[$];
		int kind;
		int len;
		int b;
		int pick;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			len = $urandom_range(0, 12);
			repeat (len) text.push_back(rip_pkg::CHAR_BITS'($urandom_range(1, 255)));
		end else begin
			b = (r == rip_pkg::BASE_AUTO) ? 10 : (r > 36 ? 36 : int'(r));
			pick = $urandom_range(0, 3);
			if (pick == 0 && (r == rip_pkg::BASE_AUTO || r == rip_pkg::BASE_HEX)) begin
				text.push_back(rip_pkg::CHAR_0);
				text.push_back($urandom_range(0, 1) ? rip_pkg::CHAR_LX : rip_pkg::CHAR_UX);
				b = 16;
			end else if (pick == 1 && r == rip_pkg::BASE_AUTO) begin
				text.push_back(rip_pkg::CHAR_0);
				b = 8;
			end
			pick = $urandom_range(0, 9);
			if (pick < 5)
				len = $urandom_range(0, 6);
			else if (pick < 8)
				len = $urandom_range(7, 24);
			else
				len = $urandom_range(25, 70);
			repeat (len) text.push_back(digit_char($urandom_range(0, b - 1)));
			if (kind <= 2)
				repeat ($urandom_range(1, 4))
					text.push_back(rip_pkg::CHAR_BITS'($urandom_range(1, 255)));
		end
		text.push_back(rip_pkg::CHAR_NUL);
		foreach (text[i])
			push_char(text[i]);
	endtask

	initial begin : stimulus
		logic [rip_pkg::BASE_BITS-1:0] seg_radix[12];
		int start;
		seg_radix = '{6'd0, 6'd10, 6'd16, 6'd36, 6'd1, 6'd8, 6'd63, 6'd2, 6'd0, 6'd16,
			6'd27, 6'd0};
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		char_if.valid = 1'b0;
		char_if.char_code = '0;
		send_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		chars_sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("");
		send_text("0");
		send_text("0x1F");
		send_text("0x");
		send_text("017");
		send_text("9z");
		send_text("18446744073709551615");
		send_text("18446744073709551616");
		send_text("0xFFFFFFFFFFFFFFFF");
		send_text("0X10000000000000000");
		push_char(8'h37);
		push_char(8'h80);
		push_char(8'hFF);
		push_char(rip_pkg::CHAR_NUL);
		wait_drain();
		write_radix(rip_pkg::BASE_HEX);
		send_text("0x");
		send_text("0xfF");
		send_text("0g");
		wait_drain();
		write_radix(6'd1);
		send_text("0010");
		wait_drain();
		write_radix(6'd63);
		send_text("zZ9");
		wait_drain();
		write_radix(6'd36);
		send_text("zz");
		wait_drain();
		write_radix(rip_pkg::BASE_DEC);
		push_char(8'h31);
		push_char(8'h32);
		wait_drain();
		write_radix(6'd2);
		push_char(8'h39);
		push_char(rip_pkg::CHAR_NUL);
		wait_drain();

		// The receiver holds off while short strings keep coming, so the block backs up.
		hold_req = 1'b1;
		repeat (80) send_text("5");
		wait_drain();

		for (int seg = 0; seg < 12; seg++) begin
			write_radix(seg_radix[seg]);
			case (seg % 4)
				0: begin
					send_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_pct = 61;
					stall_pct = 0;
				end
				2: begin
					send_pct = 0;
					stall_pct = 61;
				end
				default: begin
					send_pct = 17;
					stall_pct = 17;
				end
			endcase
			start = chars_sent;
			while (chars_sent - start < 125)
				send_random_string(seg_radix[seg]);
			wait_drain();
		end

		wait_drain();
		repeat (10) @(posedge clk);
		if (sb.expected_q.size() != 0) begin
			$error("%0d expected results never arrived", sb.expected_q.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
